/* rtl/csmacd_pkg.sv */
package csmacd_pkg;

   localparam int unsigned TICK_WIDTH      = 10;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   // Reset values of the timeout registers
   localparam logic [TICK_WIDTH-1:0] RESET_HIGH_TICKS = 10'd52;
   localparam logic [TICK_WIDTH-1:0] RESET_LOW_TICKS  = 10'd830;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HIGH_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LOW_TIMEOUT  = 2'd1;

   typedef enum logic [1:0] {
      CH_IDLE      = 2'd0,
      CH_BUSY      = 2'd1,
      CH_COLLISION = 2'd2
   } chan_state_type;

   typedef struct packed {
      logic                  line_level;
      logic [TICK_WIDTH-1:0] backoff_draw;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] channel_state;
      logic       tx_permit;
      logic       collision_hold;
      logic       restart_pulse;
   } rsp_payload_type;

endpackage

/* rtl/csma_cd_channel_monitor_top.sv */
// CSMA/CD channel monitor. Each request transaction is one tick of the bus
// timebase (sampled line level plus a random backoff draw) and yields exactly
// one response transaction with the channel state, transmit permission,
// collision hold and restart pulse for that tick. A tick is taken every clock
// cycle unless the response is stalled: all edge detection, timeout and backoff
// counting is one pass of logic from the state registers into the response
// register, and req_ready stays high while the response register is empty or
// is being drained, so the sustained rate is one tick per cycle. The timeout
// registers (index 0 high timeout, index 1 low timeout) are written through
// the csr port, which is always ready; a zero timeout acts as one tick and writes
// to other indexes are dropped. Write them only while the block is idle.
module csma_cd_channel_monitor_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  csmacd_pkg::req_payload_type              req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output csmacd_pkg::rsp_payload_type              rsp_data,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [csmacd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [csmacd_pkg::TICK_WIDTH-1:0]        csr_wdata
);
   import csmacd_pkg::*;

   // Configuration registers
   logic [TICK_WIDTH-1:0] high_ticks_ff, high_ticks_in;
   logic [TICK_WIDTH-1:0] low_ticks_ff, low_ticks_in;

   // Channel state
   logic                  level_high_ff, level_high_in;
   chan_state_type        chan_state_ff, chan_state_in;
   logic [TICK_WIDTH-1:0] timeout_count_ff, timeout_count_in;
   logic                  timeout_armed_ff, timeout_armed_in;
   logic [TICK_WIDTH-1:0] backoff_count_ff, backoff_count_in;
   logic                  backoff_active_ff, backoff_active_in;
   logic                  permit_ff, permit_in;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                  req_fire;
   logic                  restart;
   logic [TICK_WIDTH-1:0] load_raw;
   logic [TICK_WIDTH-1:0] timeout_dec;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Register writes
   always_comb begin
      high_ticks_in = high_ticks_ff;
      low_ticks_in  = low_ticks_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_HIGH_TIMEOUT: high_ticks_in = csr_wdata;
            REG_LOW_TIMEOUT:  low_ticks_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // One tick of carrier sense, timeout and backoff
   always_comb begin
      level_high_in     = level_high_ff;
      chan_state_in     = chan_state_ff;
      timeout_count_in  = timeout_count_ff;
      timeout_armed_in  = timeout_armed_ff;
      backoff_count_in  = backoff_count_ff;
      backoff_active_in = backoff_active_ff;
      permit_in         = permit_ff;
      restart           = 1'b0;

      load_raw    = req_data.line_level ? high_ticks_ff : low_ticks_ff;
      timeout_dec = (timeout_count_ff != '0) ? timeout_count_ff - 1'b1 : timeout_count_ff;

      // backoff runs down first; a collision below reloads it
      if (backoff_active_ff) begin
         if (backoff_count_ff != '0) begin
            backoff_count_in = backoff_count_ff - 1'b1;
         end
         if (backoff_count_ff <= TICK_WIDTH'(1)) begin
            backoff_active_in = 1'b0;
         end
      end

      if (req_data.line_level != level_high_ff) begin
         // edge: rearm with the timeout for the new level, zero acts as one
         level_high_in    = req_data.line_level;
         timeout_count_in = (load_raw == '0) ? TICK_WIDTH'(1) : load_raw;
         timeout_armed_in = 1'b1;
         chan_state_in    = CH_BUSY;
      end else if (timeout_armed_ff) begin
         timeout_count_in = timeout_dec;
         if (timeout_dec == '0) begin
            timeout_armed_in = 1'b0;
            if (!level_high_ff) begin
               chan_state_in = CH_IDLE;
               permit_in     = 1'b1;
            end else begin
               chan_state_in     = CH_COLLISION;
               permit_in         = 1'b0;
               restart           = 1'b1;
               backoff_count_in  = req_data.backoff_draw;
               backoff_active_in = (req_data.backoff_draw != '0);
            end
         end
      end

      rsp_data_in.channel_state  = chan_state_in;
      rsp_data_in.tx_permit      = permit_in;
      rsp_data_in.collision_hold = backoff_active_in;
      rsp_data_in.restart_pulse  = restart;

      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);
   end

   // State and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         high_ticks_ff     <= RESET_HIGH_TICKS;
         low_ticks_ff      <= RESET_LOW_TICKS;
         level_high_ff     <= 1'b0;
         chan_state_ff     <= CH_IDLE;
         timeout_count_ff  <= '0;
         timeout_armed_ff  <= 1'b0;
         backoff_count_ff  <= '0;
         backoff_active_ff <= 1'b0;
         permit_ff         <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         high_ticks_ff <= high_ticks_in;
         low_ticks_ff  <= low_ticks_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (req_fire) begin
            level_high_ff     <= level_high_in;
            chan_state_ff     <= chan_state_in;
            timeout_count_ff  <= timeout_count_in;
            timeout_armed_ff  <= timeout_armed_in;
            backoff_count_ff  <= backoff_count_in;
            backoff_active_ff <= backoff_active_in;
            permit_ff         <= permit_in;
         end
      end
   end

   // Response payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* rtl/csmacd_checker.sv */
module csmacd_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_ready,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   input  csmacd_pkg::rsp_payload_type              rsp_data
);
   import csmacd_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // an empty output register never blocks the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // each accepted tick shows up as a response in the next cycle
   a_one_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted tick produced no response");

   // a restart only comes with a declared collision
   a_restart_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.restart_pulse |->
         rsp_data.channel_state == CH_COLLISION)
      else $error("restart pulse outside collision");

   // no permission while the channel sits in collision
   a_no_permit_collision: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.channel_state == CH_COLLISION |-> !rsp_data.tx_permit)
      else $error("transmit permitted during collision");

endmodule

bind csma_cd_channel_monitor_top csmacd_checker u_csmacd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
